/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define WCPI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must never be true outside reset.
`define WCPI_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define WCPI_ASSERT(lbl, prop, msg)
`define WCPI_NEVER(lbl, expr, msg)
`endif

`endif

/* rtl/wcpi_pkg.sv */
// ---------------------------------------------------------------------------
// wcpi_pkg
// Shared types and codes of the windowed posting list intersection block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wcpi_pkg;

  localparam int ID_W     = 32;
  localparam int ACTION_W = 3;
  localparam int CIDX_W   = 4;
  localparam int CC_W     = 5;
  localparam int KIND_W   = 2;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // Input actions.
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_HEAD  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_START = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_ADD   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_EVAL  = 3'd4;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_BASE      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MATCH     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EXHAUSTED = 2'd3;

  // Register index, taken from the word-select bit of paddr.
  localparam logic REG_CLAUSE_COUNT = 1'b0;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } wcpi_alu_op_t;

  // Write strobes from the sequencer into the clause store.
  typedef struct packed {
    logic clear_heads;
    logic head_set;
    logic min_write;
    logic bits_clear;
    logic bit_set;
  } wcpi_store_ctl_t;

endpackage

/* rtl/wcpi_alu.sv */
// ---------------------------------------------------------------------------
// wcpi_alu
// Shared 32-bit add / subtract unit with carry or borrow out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wcpi_alu (
  input  wcpi_pkg::wcpi_alu_op_t      op,
  input  logic [wcpi_pkg::ID_W-1:0]   a,
  input  logic [wcpi_pkg::ID_W-1:0]   b,
  output logic [wcpi_pkg::ID_W:0]     res
);
  import wcpi_pkg::*;

  // The top bit is the carry for an add and the borrow (a < b) for a subtract.
  always_comb begin
    case (op)
      ALU_ADD: res = {1'b0, a} + {1'b0, b};
      ALU_SUB: res = {1'b0, a} - {1'b0, b};
      default: res = '0;
    endcase
  end

endmodule

/* rtl/wcpi_clause_store.sv */
// ---------------------------------------------------------------------------
// wcpi_clause_store
// Per-clause head minima, head flags and window bitmaps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wcpi_clause_store #(
  parameter int  MAX_CLAUSES = 16,
  parameter int  WINDOW_BITS = 64,
  localparam int AW = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1,
  localparam int OW = $clog2(WINDOW_BITS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  wcpi_pkg::wcpi_store_ctl_t    ctl,
  input  logic [AW-1:0]                waddr,
  input  logic [wcpi_pkg::ID_W-1:0]    wmin,
  input  logic [OW-1:0]                woff,
  input  logic [AW-1:0]                raddr,
  output logic [wcpi_pkg::ID_W-1:0]    min_rd,
  output logic                         has_rd,
  output logic [WINDOW_BITS-1:0]       bits_rd
);
  import wcpi_pkg::*;

  logic [ID_W-1:0]        min_head [MAX_CLAUSES];
  logic                   has_head [MAX_CLAUSES];
  logic [WINDOW_BITS-1:0] win_bits [MAX_CLAUSES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CLAUSES; i++) begin
        min_head[i] <= '1;
        has_head[i] <= 1'b0;
        win_bits[i] <= '0;
      end
    end else begin
      if (ctl.clear_heads) begin
        for (int i = 0; i < MAX_CLAUSES; i++) begin
          min_head[i] <= '1;
          has_head[i] <= 1'b0;
        end
      end
      if (ctl.head_set) begin
        has_head[waddr] <= 1'b1;
      end
      if (ctl.min_write) begin
        min_head[waddr] <= wmin;
      end
      if (ctl.bits_clear) begin
        for (int i = 0; i < MAX_CLAUSES; i++) begin
          win_bits[i] <= '0;
        end
      end
      if (ctl.bit_set) begin
        win_bits[waddr][woff] <= 1'b1;
      end
    end
  end

  assign min_rd  = min_head[raddr];
  assign has_rd  = has_head[raddr];
  assign bits_rd = win_bits[raddr];

endmodule

/* rtl/windowed_cnf_posting_intersect.sv */
// ---------------------------------------------------------------------------
// windowed_cnf_posting_intersect
// One window of an AND-of-ORs intersection over sorted value-id lists.
// ---------------------------------------------------------------------------
// The block takes one input word at a time and is stalled until that word is
// finished. Clear, head and add words are accepted in the idle state and
// update the clause store in the decode state, head and add words through
// the shared add/subtract unit. A start word walks the active clauses one
// per cycle through the same unit, then offers its result.
// An evaluate word ANDs one clause bitmap per cycle into an accumulator and
// then shifts the accumulator one bit per cycle, holding on a set bit while
// the result side stalls, and offers a matching id for each set bit. Results
// leave through a single output register, so a finished result may wait
// there while the next input word is accepted. Window ids are formed as
// window base plus bit position and wrap at 32 bits. clause_count is
// written through the APB port at byte address 0; zero acts as one, and
// values above MAX_CLAUSES act as MAX_CLAUSES.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module windowed_cnf_posting_intersect #(
  parameter int WINDOW_BITS = 64,
  parameter int MAX_CLAUSES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wcpi_pkg::PADDR_W-1:0]     paddr,
  input  logic [wcpi_pkg::PDATA_W-1:0]     pwdata,
  output logic [wcpi_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready,
  // Input channel
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [wcpi_pkg::ACTION_W-1:0]    action,
  input  logic [wcpi_pkg::CIDX_W-1:0]      clause_index,
  input  logic [wcpi_pkg::ID_W-1:0]        value_id,
  // Result channel
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [wcpi_pkg::KIND_W-1:0]      kind,
  output logic [wcpi_pkg::ID_W-1:0]        result_id,
  output logic                             last
);
  import wcpi_pkg::*;

  localparam int AW    = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
  localparam int OW    = $clog2(WINDOW_BITS);
  localparam int CNT_W = $clog2(MAX_CLAUSES + 1);
  localparam int NW    = (CNT_W > CC_W) ? CNT_W : CC_W;

  localparam logic [NW-1:0]   MAX_N      = NW'(MAX_CLAUSES);
  localparam logic [ID_W-1:0] WIN_LIMIT  = ID_W'(WINDOW_BITS);

  // Sequencer states.
  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_DECODE     = 3'd1;
  localparam logic [2:0] S_WALK_START = 3'd2;
  localparam logic [2:0] S_WALK_AND   = 3'd3;
  localparam logic [2:0] S_SCAN       = 3'd4;
  localparam logic [2:0] S_PUT        = 3'd5;

  // Control registers.
  logic [2:0]            state;
  logic [CC_W-1:0]       clause_count;
  logic [ID_W-1:0]       window_base;

  // Datapath registers: the captured word and the walk/scan working state.
  logic [ACTION_W-1:0]   act_q;
  logic [CIDX_W-1:0]     cidx_q;
  logic [ID_W-1:0]       vid_q;
  logic [ID_W-1:0]       base_acc;
  logic [WINDOW_BITS-1:0] acc;
  logic [AW-1:0]         idx;
  logic [OW-1:0]         bit_i;
  logic [KIND_W-1:0]     put_kind;
  logic [ID_W-1:0]       put_id;

  // Clause store interface.
  wcpi_store_ctl_t        store_ctl;
  logic [AW-1:0]          store_raddr;
  logic [ID_W-1:0]        min_rd;
  logic                   has_rd;
  logic [WINDOW_BITS-1:0] bits_rd;

  // Shared arithmetic unit.
  wcpi_alu_op_t           alu_op;
  logic [ID_W-1:0]        alu_a;
  logic [ID_W-1:0]        alu_b;
  logic [ID_W:0]          alu_res;
  logic                   alu_borrow;

  logic [NW-1:0]          n_active;
  logic [NW-1:0]          cc_ext;
  logic                   cidx_ok;
  logic [AW-1:0]          cidx_addr;
  logic                   idx_last;
  logic                   in_window;
  logic [ID_W-1:0]        walk_max;
  logic [WINDOW_BITS-1:0] acc_and;
  logic [WINDOW_BITS-1:0] acc_shift;
  logic                   slot_free;
  logic                   out_load;
  logic [KIND_W-1:0]      out_kind;
  logic [ID_W-1:0]        out_id;
  logic                   out_last;
  logic                   cfg_write;

  // The APB port has a single register; paddr's word-select bit picks it.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite &&
                     (paddr[PADDR_W-1] == REG_CLAUSE_COUNT);
  assign prdata    = (paddr[PADDR_W-1] == REG_CLAUSE_COUNT) ?
                     PDATA_W'(clause_count) : '0;

  // Number of active clauses: zero counts as one, large values saturate.
  assign cc_ext   = NW'(clause_count);
  assign n_active = (clause_count == '0) ? NW'(1) :
                    ((cc_ext > MAX_N) ? MAX_N : cc_ext);

  assign cidx_ok   = NW'(cidx_q) < n_active;
  assign cidx_addr = AW'(cidx_q);
  assign idx_last  = (NW'(idx) + NW'(1)) == n_active;

  // The word waits in the input stage only while the sequencer is busy.
  assign item_stall = (state != S_IDLE);

  // The output register can take a new word when it is empty or draining.
  assign slot_free = !result_valid || !result_stall;

  // Operand selection for the shared add/subtract unit. Head updates compare
  // the new id with the stored minimum, id adds take the offset from the
  // window base, the start walk keeps a running maximum, and the scan adds
  // the bit position to the base.
  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = vid_q;
    alu_b  = min_rd;
    case (state)
      S_DECODE: begin
        if (act_q == ACT_ADD) begin
          alu_b = window_base;
        end
      end
      S_WALK_START: begin
        alu_a = base_acc;
        alu_b = min_rd;
      end
      S_SCAN: begin
        alu_op = ALU_ADD;
        alu_a  = window_base;
        alu_b  = ID_W'(bit_i);
      end
      default: begin
      end
    endcase
  end

  wcpi_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign alu_borrow = alu_res[ID_W];
  // The offset test works on the difference, so a window that runs past the
  // top of the id range simply sees no ids beyond it.
  assign in_window  = !alu_borrow && (alu_res[ID_W-1:0] < WIN_LIMIT);
  assign walk_max   = alu_borrow ? min_rd : base_acc;
  assign acc_and    = acc & bits_rd;
  assign acc_shift  = acc >> 1;

  // Store writes happen only in the decode cycle of a word.
  always_comb begin
    store_ctl   = '0;
    store_raddr = (state == S_DECODE) ? cidx_addr : idx;
    if (state == S_DECODE) begin
      case (act_q)
        ACT_CLEAR: begin
          store_ctl.clear_heads = 1'b1;
        end
        ACT_HEAD: begin
          store_ctl.head_set  = cidx_ok;
          store_ctl.min_write = cidx_ok && alu_borrow;
        end
        ACT_START: begin
          store_ctl.bits_clear = 1'b1;
        end
        ACT_ADD: begin
          store_ctl.bit_set = cidx_ok && in_window;
        end
        default: begin
        end
      endcase
    end
  end

  wcpi_clause_store #(
    .MAX_CLAUSES (MAX_CLAUSES),
    .WINDOW_BITS (WINDOW_BITS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (store_ctl),
    .waddr   (cidx_addr),
    .wmin    (vid_q),
    .woff    (alu_res[OW-1:0]),
    .raddr   (store_raddr),
    .min_rd  (min_rd),
    .has_rd  (has_rd),
    .bits_rd (bits_rd)
  );

  // Output word source: the scan offers matches directly, every other result
  // is staged first and offered from the put state.
  assign out_load = slot_free &&
                    ((state == S_PUT) || ((state == S_SCAN) && acc[0]));
  assign out_kind = (state == S_SCAN) ? KIND_MATCH : put_kind;
  assign out_id   = (state == S_SCAN) ? alu_res[ID_W-1:0] : put_id;
  assign out_last = (state == S_SCAN) ? (acc_shift == '0) : 1'b1;

  // Control: sequencer state, configuration, window base and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      clause_count <= CC_W'(1);
      window_base  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        clause_count <= pwdata[CC_W-1:0];
      end

      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (item_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (act_q)
            ACT_START: state <= S_WALK_START;
            ACT_EVAL:  state <= S_WALK_AND;
            default:   state <= S_IDLE;
          endcase
        end
        S_WALK_START: begin
          // A clause without a head ends the walk at once.
          if (!has_rd) begin
            state <= S_PUT;
          end else if (idx_last) begin
            window_base <= walk_max;
            state       <= S_PUT;
          end
        end
        S_WALK_AND: begin
          if (idx_last) begin
            state <= (acc_and == '0) ? S_PUT : S_SCAN;
          end
        end
        S_SCAN: begin
          if ((!acc[0] || slot_free) && (acc_shift == '0)) begin
            state <= S_IDLE;
          end
        end
        S_PUT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (out_load) begin
      kind      <= out_kind;
      result_id <= out_id;
      last      <= out_last;
    end

    case (state)
      S_IDLE: begin
        if (item_valid) begin
          act_q  <= action;
          cidx_q <= clause_index;
          vid_q  <= value_id;
        end
      end
      S_DECODE: begin
        base_acc <= '0;
        acc      <= '1;
        idx      <= '0;
      end
      S_WALK_START: begin
        if (!has_rd) begin
          put_kind <= KIND_EXHAUSTED;
          put_id   <= '0;
        end else begin
          base_acc <= walk_max;
          if (idx_last) begin
            put_kind <= KIND_BASE;
            put_id   <= walk_max;
          end else begin
            idx <= idx + AW'(1);
          end
        end
      end
      S_WALK_AND: begin
        acc <= acc_and;
        if (idx_last) begin
          put_kind <= KIND_EMPTY;
          put_id   <= window_base;
          bit_i    <= '0;
        end else begin
          idx <= idx + AW'(1);
        end
      end
      S_SCAN: begin
        // Hold on a set bit until the output register can take the match.
        if (!acc[0] || slot_free) begin
          acc   <= acc_shift;
          bit_i <= bit_i + OW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // The scan is only entered with at least one common bit left.
  `WCPI_ASSERT(a_scan_nonzero, (state == S_SCAN) |-> (acc != '0), "scan with empty accumulator")
  // Clause walks never step past the last active clause.
  `WCPI_ASSERT(a_walk_in_range, ((state == S_WALK_START) || (state == S_WALK_AND)) |-> (NW'(idx) < n_active), "clause walk out of range")
  // The window base only moves at the end of a start walk.
  `WCPI_ASSERT(a_base_from_walk, (!$past(rst) && !$stable(window_base)) |-> ($past(state) == S_WALK_START), "window base changed outside start walk")
  // A match is never offered while a held output word is stalled.
  `WCPI_NEVER(a_no_overwrite, out_load && result_valid && result_stall, "output word overwritten while stalled")

endmodule
